// File: rtl/core/jpr_pkg.sv
// Shared types, codes and helper functions for the joybus pak responder.
`timescale 1ns / 1ps
package jpr_pkg;

  localparam int PAGE_BYTES = 32;
  localparam int IDX_W      = 5;
  localparam int MEM_AW     = IDX_W + 1;
  localparam int HEX_START  = 6;
  localparam int LINE_MIN   = 70;
  localparam int POS_W      = 7;

  localparam logic [7:0]  CRC_POLY  = 8'h85;
  localparam logic [15:0] ADDR_MASK = 16'hFFE0;
  localparam logic [7:0]  MAGIC0    = 8'h52;
  localparam logic [7:0]  MAGIC1    = 8'h43;
  localparam logic [7:0]  CHAR_LF   = 8'h0A;
  localparam logic [7:0]  CHAR_CR   = 8'h0D;

  localparam logic [7:0] CMD_PROBE = 8'h00;
  localparam logic [7:0] CMD_POLL  = 8'h01;
  localparam logic [7:0] CMD_READ  = 8'h02;
  localparam logic [7:0] CMD_WRITE = 8'h03;
  localparam logic [7:0] CMD_RESET = 8'hFF;

  localparam logic [23:0] STATUS_RESET = 24'h050001;
  localparam logic [31:0] REPORT_RESET = 32'h00005042;
  localparam logic [15:0] SERVE_RESET  = 16'h8000;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_GAP  = 2'd1,
    KIND_HOST = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_STATUS = 2'd0,
    REG_REPORT = 2'd1,
    REG_SERVE  = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    REP_OK        = 2'd0,
    REP_BAD_MAGIC = 2'd1,
    REP_BAD_HEX   = 2'd2
  } report_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RD_HI,
    PH_RD_LO,
    PH_WR_HI,
    PH_WR_LO,
    PH_WR_DATA
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  typedef enum logic [1:0] {
    SEL_STATUS,
    SEL_REPORT,
    SEL_SINGLE
  } send_sel_t;

  typedef struct packed {
    logic [23:0] status_reply;
    logic [31:0] report_reply;
    logic [15:0] serve_address;
  } cfg_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] d);
    logic [7:0] c;
    logic [7:0] tap;
    c = crc_in;
    for (int b = 7; b >= 0; b--) begin
      tap = c[7] ? CRC_POLY : 8'h00;
      c = {c[6:0], d[b]} ^ tap;
    end
    return c;
  endfunction

  function automatic logic [7:0] chain_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h43;
      3'd1:    c = 8'h48;
      3'd2:    c = 8'h41;
      3'd3:    c = 8'h49;
      3'd4:    c = 8'h4E;
      3'd5:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else r = 5'd0;
    return r;
  endfunction

endpackage

// File: rtl/core/jpr_page_mem.sv
// Two-bank page memory: served page and staging page, one write and one read port.
`timescale 1ns / 1ps
module jpr_page_mem (
  input  logic                      clk,
  input  logic                      wen,
  input  logic [jpr_pkg::MEM_AW-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic                      ren,
  input  logic [jpr_pkg::MEM_AW-1:0] raddr,
  output logic [7:0]                rdata
);

  logic [7:0] mem [2**jpr_pkg::MEM_AW];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/jpr_apb_regs.sv
// APB configuration registers: status reply, report reply, serve address.
`timescale 1ns / 1ps
module jpr_apb_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output jpr_pkg::cfg_t      cfg
);

  logic             wr;
  jpr_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = jpr_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.status_reply  <= jpr_pkg::STATUS_RESET;
      cfg.report_reply  <= jpr_pkg::REPORT_RESET;
      cfg.serve_address <= jpr_pkg::SERVE_RESET;
    end else if (wr) begin
      unique case (idx)
        jpr_pkg::REG_STATUS: cfg.status_reply  <= pwdata[23:0];
        jpr_pkg::REG_REPORT: cfg.report_reply  <= pwdata;
        jpr_pkg::REG_SERVE:  cfg.serve_address <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      jpr_pkg::REG_STATUS: prdata = {8'h00, cfg.status_reply};
      jpr_pkg::REG_REPORT: prdata = cfg.report_reply;
      jpr_pkg::REG_SERVE:  prdata = {16'h0000, cfg.serve_address};
      default:             prdata = 32'h0;
    endcase
  end

endmodule

// File: rtl/core/joybus_pak_responder.sv
// Top level: joybus frame handling, host line loader and reply sequencer.
//
//  channel  | dir | payload
//  s_axis   | in  | tdata: data_byte[7:0]; tuser: kind[1:0]
//  m_axis   | out | tdata: reply_byte[7:0], host_report[9:8]; tuser: channel; tlast
//  apb      | cfg | 0x0 status_reply, 0x4 report_reply, 0x8 serve_address
//
// One item at a time. Probe, reset and poll send one reply byte after another. A
// pak read passes through the accept, then a memory read step and an output step
// for each of the 32 page bytes, and then one step for the CRC byte.
// Output stalls hold the sequencer. Synchronous reset; the page memory is not cleared.
`timescale 1ns / 1ps
module joybus_pak_responder #(
  parameter int LINE_LIMIT = 79
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // reply_byte[7:0], host_report[9:8], zeros above
  output logic        m_axis_tuser,   // channel
  output logic        m_axis_tlast,   // last_of_run
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  jpr_pkg::cfg_t      cfg;
  jpr_pkg::state_t    state, state_next;
  jpr_pkg::phase_t    phase;
  jpr_pkg::send_sel_t send_sel;
  jpr_pkg::kind_t     kind;

  logic [5:0]  frame_count;
  logic [7:0]  address_high;
  logic [7:0]  running_crc;
  logic        page_valid;
  logic        bank;
  logic [jpr_pkg::POS_W-1:0] line_position;
  logic        prefix_matches, hex_good;
  logic [3:0]  high_nibble;
  logic        magic0, magic1;
  logic [1:0]  send_cnt;
  logic        single_chan;
  logic [7:0]  single_byte;
  logic [1:0]  single_rep;
  logic        rd_serve;
  logic [jpr_pkg::IDX_W-1:0] rd_idx;
  logic [7:0]  rd_crc;

  logic        in_acc, slot_free, emit;
  logic        e_chan, e_last;
  logic [7:0]  e_byte, rd_byte;
  logic [1:0]  e_rep;
  logic        go_send, go_read;
  logic [7:0]  b;
  logic [7:0]  wcrc;
  logic [5:0]  fc_inc;
  logic [4:0]  nib;
  logic [jpr_pkg::POS_W-1:0] hex_off;
  logic        is_eol, in_hex;
  logic        mem_wen, mem_ren;
  logic [jpr_pkg::MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata, mem_rdata;
  logic [15:0] rd_addr;

  jpr_apb_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  jpr_page_mem u_mem (
    .clk   (clk),
    .wen   (mem_wen),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .ren   (mem_ren),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign kind      = jpr_pkg::kind_t'(s_axis_tuser);
  assign b         = s_axis_tdata;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !m_axis_tvalid || m_axis_tready;
  assign wcrc      = jpr_pkg::crc_byte(running_crc, b);
  assign fc_inc    = frame_count + 6'd1;
  assign nib       = jpr_pkg::hex_nibble(b);
  assign hex_off   = line_position - jpr_pkg::POS_W'(jpr_pkg::HEX_START);
  assign is_eol    = (b == jpr_pkg::CHAR_LF) || (b == jpr_pkg::CHAR_CR);
  assign in_hex    = line_position >= jpr_pkg::POS_W'(jpr_pkg::HEX_START)
                     && line_position < jpr_pkg::POS_W'(jpr_pkg::LINE_MIN);
  assign rd_addr   = {address_high, b} & jpr_pkg::ADDR_MASK;
  assign rd_byte   = rd_serve ? mem_rdata : 8'h00;

  assign mem_wen   = in_acc && kind == jpr_pkg::KIND_HOST && !is_eol
                     && line_position < jpr_pkg::POS_W'(LINE_LIMIT)
                     && in_hex && nib[4] && line_position[0] && hex_good;
  assign mem_waddr = {!bank, hex_off[jpr_pkg::IDX_W:1]};
  assign mem_wdata = {high_nibble, nib[3:0]};
  assign mem_raddr = {bank, rd_idx};

  // Decode of the accepted item into what follows it.
  always_comb begin
    go_send = 1'b0;
    go_read = 1'b0;
    if (in_acc) begin
      if (kind == jpr_pkg::KIND_BYTE) begin
        unique case (phase)
          jpr_pkg::PH_IDLE:
            go_send = b == jpr_pkg::CMD_PROBE || b == jpr_pkg::CMD_RESET
                      || b == jpr_pkg::CMD_POLL;
          jpr_pkg::PH_RD_LO:   go_read = 1'b1;
          jpr_pkg::PH_WR_DATA: go_send = fc_inc >= 6'(jpr_pkg::PAGE_BYTES);
          default: ;
        endcase
      end else if (kind == jpr_pkg::KIND_HOST) begin
        go_send = is_eol && line_position >= jpr_pkg::POS_W'(jpr_pkg::LINE_MIN)
                  && prefix_matches;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      jpr_pkg::ST_IDLE:
        if (go_send) state_next = jpr_pkg::ST_SEND;
        else if (go_read) state_next = jpr_pkg::ST_RD_ADDR;
      jpr_pkg::ST_SEND:
        if (slot_free && e_last) state_next = jpr_pkg::ST_IDLE;
      jpr_pkg::ST_RD_ADDR:
        state_next = jpr_pkg::ST_RD_DATA;
      jpr_pkg::ST_RD_DATA:
        if (slot_free) begin
          state_next = (rd_idx == jpr_pkg::IDX_W'(jpr_pkg::PAGE_BYTES - 1))
                       ? jpr_pkg::ST_SEND : jpr_pkg::ST_RD_ADDR;
        end
      default: state_next = jpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state == jpr_pkg::ST_IDLE;
    mem_ren       = state == jpr_pkg::ST_RD_ADDR;
    emit          = slot_free && (state == jpr_pkg::ST_SEND || state == jpr_pkg::ST_RD_DATA);
    e_chan = 1'b0;
    e_byte = 8'h00;
    e_rep  = 2'd0;
    e_last = 1'b0;
    if (state == jpr_pkg::ST_RD_DATA) begin
      e_byte = rd_byte;
    end else begin
      case (send_sel)
        jpr_pkg::SEL_STATUS: begin
          case (send_cnt)
            2'd0:    e_byte = cfg.status_reply[23:16];
            2'd1:    e_byte = cfg.status_reply[15:8];
            default: e_byte = cfg.status_reply[7:0];
          endcase
          e_last = send_cnt == 2'd2;
        end
        jpr_pkg::SEL_REPORT: begin
          case (send_cnt)
            2'd0:    e_byte = cfg.report_reply[31:24];
            2'd1:    e_byte = cfg.report_reply[23:16];
            2'd2:    e_byte = cfg.report_reply[15:8];
            default: e_byte = cfg.report_reply[7:0];
          endcase
          e_last = send_cnt == 2'd3;
        end
        default: begin
          e_chan = single_chan;
          e_byte = single_byte;
          e_rep  = single_rep;
          e_last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= jpr_pkg::ST_IDLE;
      m_axis_tvalid  <= 1'b0;
      phase          <= jpr_pkg::PH_IDLE;
      frame_count    <= 6'd0;
      address_high   <= 8'h00;
      running_crc    <= 8'h00;
      page_valid     <= 1'b0;
      bank           <= 1'b0;
      line_position  <= '0;
      prefix_matches <= 1'b1;
      hex_good       <= 1'b1;
      high_nibble    <= 4'h0;
      send_cnt       <= 2'd0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tuser  <= e_chan;
        m_axis_tdata  <= {6'd0, e_rep, e_byte};
        m_axis_tlast  <= e_last;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == jpr_pkg::ST_SEND && slot_free) send_cnt <= send_cnt + 2'd1;
      if (state == jpr_pkg::ST_RD_DATA && slot_free) begin
        rd_crc      <= jpr_pkg::crc_byte(rd_crc, rd_byte);
        rd_idx      <= rd_idx + jpr_pkg::IDX_W'(1);
        send_sel    <= jpr_pkg::SEL_SINGLE;
        send_cnt    <= 2'd0;
        single_chan <= 1'b0;
        single_byte <= jpr_pkg::crc_byte(rd_crc, rd_byte);
        single_rep  <= jpr_pkg::REP_OK;
      end
      if (in_acc) begin
        send_cnt <= 2'd0;
        unique case (kind)
          jpr_pkg::KIND_BYTE: begin
            unique case (phase)
              jpr_pkg::PH_IDLE: begin
                if (b == jpr_pkg::CMD_POLL) send_sel <= jpr_pkg::SEL_REPORT;
                else send_sel <= jpr_pkg::SEL_STATUS;
                if (b == jpr_pkg::CMD_READ) phase <= jpr_pkg::PH_RD_HI;
                else if (b == jpr_pkg::CMD_WRITE) phase <= jpr_pkg::PH_WR_HI;
              end
              jpr_pkg::PH_RD_HI: begin
                address_high <= b;
                phase        <= jpr_pkg::PH_RD_LO;
              end
              jpr_pkg::PH_RD_LO: begin
                rd_serve <= page_valid
                            && rd_addr == (cfg.serve_address & jpr_pkg::ADDR_MASK);
                rd_idx   <= '0;
                rd_crc   <= 8'h00;
                phase    <= jpr_pkg::PH_IDLE;
              end
              jpr_pkg::PH_WR_HI: begin
                address_high <= b;
                phase        <= jpr_pkg::PH_WR_LO;
              end
              jpr_pkg::PH_WR_LO: begin
                running_crc <= 8'h00;
                frame_count <= 6'd0;
                phase       <= jpr_pkg::PH_WR_DATA;
              end
              jpr_pkg::PH_WR_DATA: begin
                running_crc <= wcrc;
                send_sel    <= jpr_pkg::SEL_SINGLE;
                single_chan <= 1'b0;
                single_byte <= wcrc;
                single_rep  <= jpr_pkg::REP_OK;
                if (fc_inc >= 6'(jpr_pkg::PAGE_BYTES)) begin
                  phase       <= jpr_pkg::PH_IDLE;
                  frame_count <= 6'd0;
                end else begin
                  frame_count <= fc_inc;
                end
              end
              default: phase <= jpr_pkg::PH_IDLE;
            endcase
          end
          jpr_pkg::KIND_GAP: begin
            phase       <= jpr_pkg::PH_IDLE;
            frame_count <= 6'd0;
          end
          jpr_pkg::KIND_HOST: begin
            if (is_eol) begin
              send_sel    <= jpr_pkg::SEL_SINGLE;
              single_chan <= 1'b1;
              single_byte <= 8'h00;
              if (!hex_good) begin
                single_rep <= jpr_pkg::REP_BAD_HEX;
              end else if (magic0 && magic1) begin
                single_rep <= jpr_pkg::REP_OK;
                if (go_send) begin
                  bank       <= !bank;
                  page_valid <= 1'b1;
                end
              end else begin
                single_rep <= jpr_pkg::REP_BAD_MAGIC;
              end
              line_position  <= '0;
              prefix_matches <= 1'b1;
              hex_good       <= 1'b1;
              high_nibble    <= 4'h0;
            end else if (line_position < jpr_pkg::POS_W'(LINE_LIMIT)) begin
              if (line_position < jpr_pkg::POS_W'(jpr_pkg::HEX_START)) begin
                if (b != jpr_pkg::chain_char(line_position[2:0])) prefix_matches <= 1'b0;
              end else if (in_hex) begin
                if (!nib[4]) hex_good <= 1'b0;
                else if (!line_position[0]) high_nibble <= nib[3:0];
              end
              if (mem_wen && hex_off[jpr_pkg::IDX_W:1] == jpr_pkg::IDX_W'(0))
                magic0 <= mem_wdata == jpr_pkg::MAGIC0;
              if (mem_wen && hex_off[jpr_pkg::IDX_W:1] == jpr_pkg::IDX_W'(1))
                magic1 <= mem_wdata == jpr_pkg::MAGIC1;
              line_position <= line_position + jpr_pkg::POS_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/core/jpr_checker.sv
// Port-level checks for the joybus pak responder, bound to the top level.
`timescale 1ns / 1ps
module jpr_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item dropped or changed under stall");

  a_host_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[7:0] == 8'h00)
    else $error("host report not a single zero-byte item");

  a_joy_no_rep: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:8] == 8'h00)
    else $error("joybus item carries report bits");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken in the middle of a reply run");

endmodule

bind joybus_pak_responder jpr_port_checks u_jpr_port_checks (.*);
